[rtl/assert_macros.svh]
// assertion helpers included by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, expr, msg)
`endif
`endif

[rtl/tlge_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package tlge_pkg;

   localparam int ROW_BITS   = 64;
   localparam int INDEX_BITS = 6;

   typedef logic [1:0] req_code_type;

   localparam req_code_type REQ_WRITE = 2'd0;
   localparam req_code_type REQ_READ  = 2'd1;
   localparam req_code_type REQ_STEP  = 2'd2;
   localparam req_code_type REQ_CLEAR = 2'd3;

   typedef struct packed {
      req_code_type          req_type;
      logic [INDEX_BITS-1:0] row_index;
      logic [ROW_BITS-1:0]   row_bits;
   } req_item_type;

   typedef struct packed {
      logic [ROW_BITS-1:0] read_bits;
      logic                done_res;
   } rsp_item_type;

   typedef struct packed {
      logic shift;
      logic clear;
   } cell_ctl_type;

endpackage
`default_nettype wire

[rtl/tlge_req_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface tlge_req_if;
   logic                   valid;
   logic                   ready;
   tlge_pkg::req_item_type item;

   modport source (output valid, output item, input ready);
   modport sink (input valid, input item, output ready);
endinterface
`default_nettype wire

[rtl/tlge_rsp_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface tlge_rsp_if;
   logic                   valid;
   logic                   ready;
   tlge_pkg::rsp_item_type item;

   modport source (output valid, output item, input ready);
   modport sink (input valid, input item, output ready);
endinterface
`default_nettype wire

[rtl/tlge_row_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
module tlge_row_cell #(
   parameter int GRID_WIDTH = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  tlge_pkg::cell_ctl_type ctl,
   input  logic [GRID_WIDTH-1:0]  row_in,
   output logic [GRID_WIDTH-1:0]  row_out
);

   logic [GRID_WIDTH-1:0] row_ff;

   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         row_ff <= '0;
      end else if (ctl.shift) begin
         row_ff <= row_in;
      end
   end

   assign row_out = row_ff;

endmodule
`default_nettype wire

[rtl/tlge_next_row.sv]
`timescale 1ns / 1ps
`default_nettype none
module tlge_next_row #(
   parameter int GRID_WIDTH = 64
) (
   input  logic [GRID_WIDTH-1:0] prev_row,
   input  logic [GRID_WIDTH-1:0] cur_row,
   input  logic [GRID_WIDTH-1:0] next_row,
   output logic [GRID_WIDTH-1:0] new_row
);

   for (genvar c = 0; c < GRID_WIDTH; c++) begin : g_col
      localparam int LEFT  = (c + GRID_WIDTH - 1) % GRID_WIDTH;
      localparam int RIGHT = (c + 1) % GRID_WIDTH;
      logic [3:0] count;

      assign count = 4'(prev_row[LEFT]) + 4'(prev_row[c]) + 4'(prev_row[RIGHT])
                   + 4'(cur_row[LEFT]) + 4'(cur_row[RIGHT])
                   + 4'(next_row[LEFT]) + 4'(next_row[c]) + 4'(next_row[RIGHT]);

      // b3/s23
      assign new_row[c] = (count == 4'd3) || (cur_row[c] && (count == 4'd2));
   end

endmodule
`default_nettype wire

[rtl/toroidal_life_generation_engine_top.sv]
// channel   role     payload
// req_chan  sink     req_type, row_index, row_bits
// rsp_chan  source   read_bits, done_res
//
// for write, read and step the ring of row cells turns once
// clear does not turn the ring; one item is in work at a time
// a step sees each row at the head of the ring and puts its new row at the tail
// reset is synchronous and clears every cell
// a finished result waits in the output register; the next item is taken meanwhile
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module toroidal_life_generation_engine_top #(
   parameter int GRID_HEIGHT = 64,
   parameter int GRID_WIDTH  = 64
) (
   input  logic       clock,
   input  logic       reset,
   tlge_req_if.sink   req_chan,
   tlge_rsp_if.source rsp_chan
);

   localparam int CNT_BITS = $clog2(GRID_HEIGHT);
   localparam int CMP_BITS = (CNT_BITS > tlge_pkg::INDEX_BITS) ? CNT_BITS
                                                              : tlge_pkg::INDEX_BITS;
   localparam logic [CNT_BITS-1:0] LAST_ROW = CNT_BITS'(GRID_HEIGHT - 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_RUN,
      S_FINISH
   } state_type;

   state_type                        state_ff, state_in;
   logic [CNT_BITS-1:0]              cnt_ff, cnt_in;
   tlge_pkg::req_code_type           op_ff, op_in;
   logic [tlge_pkg::INDEX_BITS-1:0]  idx_ff, idx_in;
   logic [GRID_WIDTH-1:0]            wbits_ff, wbits_in;
   logic [GRID_WIDTH-1:0]            rd_ff, rd_in;
   logic [GRID_WIDTH-1:0]            prev_ff, prev_in;
   logic [GRID_WIDTH-1:0]            first_ff, first_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   tlge_pkg::rsp_item_type           rsp_data_ff, rsp_data_in;

   logic [GRID_WIDTH-1:0] cells_q [GRID_HEIGHT];
   logic [GRID_WIDTH-1:0] head_row, prev_row, next_row, new_row, tail_row;
   tlge_pkg::cell_ctl_type ctl;
   logic accept, match, last;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign accept = req_chan.valid && req_chan.ready;
   assign match  = (CMP_BITS'(cnt_ff) == CMP_BITS'(idx_ff));
   assign last   = (cnt_ff == LAST_ROW);

   assign head_row = cells_q[0];
   assign prev_row = (cnt_ff == '0) ? cells_q[GRID_HEIGHT-1] : prev_ff;
   assign next_row = last ? first_ff : cells_q[1];

   tlge_next_row #(
      .GRID_WIDTH(GRID_WIDTH)
   ) u_next_row (
      .prev_row(prev_row),
      .cur_row (head_row),
      .next_row(next_row),
      .new_row (new_row)
   );

   always_comb begin
      case (op_ff)
         tlge_pkg::REQ_STEP:  tail_row = new_row;
         tlge_pkg::REQ_WRITE: tail_row = match ? wbits_ff : head_row;
         default:             tail_row = head_row;
      endcase
   end

   assign ctl.shift = (state_ff == S_RUN);
   assign ctl.clear = accept && (req_chan.item.req_type == tlge_pkg::REQ_CLEAR);

   for (genvar i = 0; i < GRID_HEIGHT; i++) begin : g_row
      logic [GRID_WIDTH-1:0] row_in;
      if (i == GRID_HEIGHT - 1) begin : g_tail
         assign row_in = tail_row;
      end else begin : g_body
         assign row_in = cells_q[i+1];
      end
      tlge_row_cell #(
         .GRID_WIDTH(GRID_WIDTH)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .ctl    (ctl),
         .row_in (row_in),
         .row_out(cells_q[i])
      );
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      op_in        = op_ff;
      idx_in       = idx_ff;
      wbits_in     = wbits_ff;
      rd_in        = rd_ff;
      prev_in      = prev_ff;
      first_in     = first_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in    = req_chan.item.req_type;
               idx_in   = req_chan.item.row_index;
               wbits_in = req_chan.item.row_bits[GRID_WIDTH-1:0];
               rd_in    = '0;
               cnt_in   = '0;
               state_in = (req_chan.item.req_type == tlge_pkg::REQ_CLEAR) ? S_FINISH : S_RUN;
            end
         end
         S_RUN: begin
            prev_in = head_row;
            if (cnt_ff == '0) begin
               first_in = head_row;
            end
            if ((op_ff == tlge_pkg::REQ_READ) && match) begin
               rd_in = head_row;
            end
            if (last) begin
               cnt_in   = '0;
               state_in = S_FINISH;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.read_bits = tlge_pkg::ROW_BITS'(rd_ff);
               rsp_data_in.done_res  = 1'b1;
               state_in              = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff       <= op_in;
      idx_ff      <= idx_in;
      wbits_ff    <= wbits_in;
      rd_ff       <= rd_in;
      prev_ff     <= prev_in;
      first_ff    <= first_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.item  = rsp_data_ff;

   `ASSERT_PROP(a_one_item, clock, reset, (req_chan.valid && req_chan.ready) |=> !req_chan.ready, "second item taken while busy")
   `ASSERT_NEVER(a_cnt_idle, clock, reset, (state_ff == S_IDLE) && (cnt_ff != '0), "row counter not home when idle")
   `ASSERT_PROP(a_done, clock, reset, rsp_chan.valid |-> rsp_chan.item.done_res, "result without done flag")
   `ASSERT_PROP(a_rsp_src, clock, reset, $rose(rsp_valid_ff) |-> ($past(state_ff) == S_FINISH), "result raised outside finish")

endmodule
`default_nettype wire
